// ===== hw/rtl/upc_pkg.sv =====
// Shared types, constants and helper functions of the URI percent codec.
// No dependencies; all other files of the codec refer to this package.
`default_nettype none

package upc_pkg;

  // Number of commands buffered between the front and the back.
  localparam int unsigned QueueDepth = 4;

  localparam int unsigned CfgIdxW = 2;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgDirection = 2'd0;
  localparam cfg_idx_t CfgComponent = 2'd1;
  localparam cfg_idx_t CfgSecondary = 2'd2;

  localparam logic [7:0] PctChar = 8'h25;

  typedef struct packed {
    logic direction;
    logic component_mode;
    logic secondary_mode;
  } cfg_t;

  // OP_LIT sends the byte as it is, OP_HEX sends '%' and two hex digits.
  typedef enum logic {
    OP_LIT = 1'b0,
    OP_HEX = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       str_end;
  } cmd_t;

  // Upper-case ASCII hex digit of a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'b0000, nib};
    if (nib < 4'd10) begin
      return 8'h30 + wide;
    end
    return 8'h37 + wide;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/upc_if.sv =====
// Stream interfaces of the URI percent codec: input bytes, result bytes and
// register writes. Depends on upc_pkg.
`default_nettype none

interface upc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_end;

  modport source (output valid, output in_byte, output in_end, input ready);
  modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

interface upc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_end,
                  output ready);
endinterface

interface upc_cfg_if;
  logic              valid;
  logic              ready;
  upc_pkg::cfg_idx_t index;
  logic              data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/upc_front.sv =====
// Front of the codec: accepts input bytes, tracks the escape state of the
// decoder and turns each byte into at most one command. Depends on upc_pkg, upc_if.
`default_nettype none

module upc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire upc_pkg::cfg_t cfg_i,
  upc_in_if.sink             in_i,
  input  wire logic          full_i,
  output logic               push_o,
  output upc_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ESC_IDLE = 4'b0001,
    ESC_PCT  = 4'b0010,
    ESC_HIGH = 4'b0100,
    ESC_BAD  = 4'b1000
  } esc_e;

  esc_e       esc_q, esc_d;
  logic [3:0] nib_q, nib_d;
  logic       accept;
  logic       emit;
  logic [4:0] hv;

  function automatic logic must_encode(input logic [7:0] c, input logic comp,
                                       input logic sec);
    logic keep;
    keep = 1'b0;
    if (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) begin
      keep = 1'b1;
    end
    // - _ . ! ~ * ' ( )
    if (c inside {8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29}) begin
      keep = 1'b1;
    end
    if (!comp) begin
      // ; / ? : @ & = + $ , #
      if (c inside {8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26, 8'h3D, 8'h2B, 8'h24,
                    8'h2C, 8'h23}) begin
        keep = 1'b1;
      end
      if (c == upc_pkg::PctChar && sec) begin
        keep = 1'b1;
      end
    end
    return !keep;
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) begin
      return {1'b1, c[3:0]};
    end
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      return {1'b1, c[3:0] + 4'd9};
    end
    return 5'b00000;
  endfunction

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept && emit;
  assign hv         = hex_value(in_i.in_byte);

  always_comb begin
    esc_d         = esc_q;
    nib_d         = nib_q;
    emit          = 1'b0;
    cmd_o.op      = upc_pkg::OP_LIT;
    cmd_o.data    = in_i.in_byte;
    cmd_o.str_end = in_i.in_end;
    if (!cfg_i.direction) begin
      esc_d = ESC_IDLE;
      nib_d = 4'h0;
      emit  = 1'b1;
      if (must_encode(in_i.in_byte, cfg_i.component_mode, cfg_i.secondary_mode)) begin
        cmd_o.op = upc_pkg::OP_HEX;
      end
    end else begin
      case (esc_q)
        ESC_IDLE: begin
          if (in_i.in_byte == upc_pkg::PctChar) begin
            esc_d      = ESC_PCT;
            nib_d      = 4'h0;
            emit       = in_i.in_end;
            cmd_o.data = 8'h00;
          end else begin
            emit = 1'b1;
          end
        end
        ESC_PCT: begin
          // A truncated escape flushes whatever digit value it holds so far.
          emit = in_i.in_end;
          if (hv[4]) begin
            esc_d      = ESC_HIGH;
            nib_d      = hv[3:0];
            cmd_o.data = {4'h0, hv[3:0]};
          end else begin
            esc_d      = ESC_BAD;
            nib_d      = 4'h0;
            cmd_o.data = 8'h00;
          end
        end
        ESC_HIGH: begin
          esc_d      = ESC_IDLE;
          emit       = 1'b1;
          cmd_o.data = hv[4] ? {nib_q, hv[3:0]} : {4'h0, nib_q};
        end
        default: begin
          esc_d      = ESC_IDLE;
          emit       = 1'b1;
          cmd_o.data = 8'h00;
        end
      endcase
      if (in_i.in_end) begin
        esc_d = ESC_IDLE;
        nib_d = 4'h0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= ESC_IDLE;
      nib_q <= 4'h0;
    end else if (accept) begin
      esc_q <= esc_d;
      nib_q <= nib_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/upc_queue.sv =====
// Short command queue between the front and the back of the codec.
// Depends on upc_pkg.
`default_nettype none

module upc_queue #(
  parameter int unsigned Depth = upc_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire upc_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output upc_pkg::cmd_t      cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  upc_pkg::cmd_t   entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/upc_back.sv =====
// Back of the codec: carries out queued commands, one result byte per cycle
// unless stalled, into a registered output stage. Depends on upc_pkg, upc_if.
`default_nettype none

module upc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire upc_pkg::cmd_t cmd_i,
  output logic               pop_o,
  upc_out_if.source          out_o
);

  typedef enum logic [2:0] {
    SEQ_PCT = 3'b001,
    SEQ_HI  = 3'b010,
    SEQ_LO  = 3'b100
  } seq_e;

  seq_e       seq_q, seq_d;
  logic       ov_q, ov_d;
  logic [7:0] byte_q, byte_d;
  logic       rl_q, rl_d;
  logic       se_q, se_d;
  logic       load;
  logic       legal;
  logic       last;

  // The output register may be refilled when it is empty or being taken.
  assign load = !ov_q || out_o.ready;

  always_comb begin
    byte_d = cmd_i.data;
    rl_d   = 1'b0;
    se_d   = 1'b0;
    last   = 1'b0;
    legal  = 1'b1;
    seq_d  = seq_q;
    case (seq_q)
      SEQ_PCT: begin
        if (cmd_i.op == upc_pkg::OP_HEX) begin
          byte_d = upc_pkg::PctChar;
        end else begin
          rl_d = 1'b1;
          se_d = cmd_i.str_end;
          last = 1'b1;
        end
      end
      SEQ_HI: begin
        byte_d = upc_pkg::hex_char(cmd_i.data[7:4]);
      end
      SEQ_LO: begin
        byte_d = upc_pkg::hex_char(cmd_i.data[3:0]);
        rl_d   = 1'b1;
        se_d   = cmd_i.str_end;
        last   = 1'b1;
      end
      default: begin
        legal = 1'b0;
      end
    endcase

    pop_o = 1'b0;
    ov_d  = ov_q;
    if (load) begin
      ov_d = valid_i && legal;
      if (!legal) begin
        seq_d = SEQ_PCT;
      end else if (valid_i) begin
        if (last) begin
          pop_o = 1'b1;
          seq_d = SEQ_PCT;
        end else if (seq_q == SEQ_PCT) begin
          seq_d = SEQ_HI;
        end else begin
          seq_d = SEQ_LO;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SEQ_PCT;
      ov_q  <= 1'b0;
    end else begin
      seq_q <= seq_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      rl_q   <= rl_d;
      se_q   <= se_d;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.run_last   = rl_q;
  assign out_o.string_end = se_q;

endmodule

`default_nettype wire

// ===== hw/rtl/uri_percent_codec_top.sv =====
// Top level of the URI percent codec: register file, front, command queue
// and back. Depends on upc_pkg, upc_if, upc_front, upc_queue, upc_back.
//
//   channel  direction  payload                          transfer when
//   in_i     sink       in_byte[7:0], in_end             valid && ready
//   out_o    source     out_byte[7:0], run_last, string_end  valid && ready
//   cfg_i    sink       index[1:0], data                 valid && ready (ready is 1)
//
// The front takes one byte per cycle while the queue has room. The back sends
// one result byte per cycle while the output is taken: a literal or decoded
// byte gives one result byte, an encoded byte three ('%' and two hex digits),
// so the back's single output byte sets the sustained rate. The first result
// of an input passes through the queue and then the output register.
// Reset clears the registers, the escape state and the queue. A stall on the
// output fills the queue before the input side sees ready drop.
`default_nettype none

module uri_percent_codec_top #(
  parameter int unsigned QueueDepth = upc_pkg::QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  upc_in_if.sink    in_i,
  upc_out_if.source out_o,
  upc_cfg_if.sink   cfg_i
);

  upc_pkg::cfg_t cfg_q;
  logic          push;
  logic          full;
  logic          pop;
  logic          q_valid;
  upc_pkg::cmd_t front_cmd;
  upc_pkg::cmd_t back_cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        upc_pkg::CfgDirection: cfg_q.direction      <= cfg_i.data;
        upc_pkg::CfgComponent: cfg_q.component_mode <= cfg_i.data;
        upc_pkg::CfgSecondary: cfg_q.secondary_mode <= cfg_i.data;
        default: ;
      endcase
    end
  end

  upc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (front_cmd)
  );

  upc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (back_cmd)
  );

  upc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .cmd_i   (back_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for uri_percent_codec_top: directed and random byte streams
// through the encoder and decoder settings, checked by an in-bench predictor.
// Depends on upc_pkg, the upc_if interfaces and the codec RTL.

module tb;

  localparam upc_pkg::cfg_idx_t CfgUnused = 2'd3;
  localparam int unsigned MaxCycles    = 200000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned IdlePct      = 7;
  localparam int unsigned NumPhases    = 9;
  localparam int unsigned PhaseItems   = 41;

  // Decoder escape progress.
  localparam logic [1:0] EscIdle = 2'd0;
  localparam logic [1:0] EscPct  = 2'd1;
  localparam logic [1:0] EscHigh = 2'd2;
  localparam logic [1:0] EscBad  = 2'd3;

  localparam string HexDigits = "0123456789ABCDEF";
  localparam string HexText   = "0123456789abcdefABCDEF";
  localparam string UriText   = "AZaz09-_.!~*'();/?:@&=+$,#% Gg";

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       string_end;
  } out_byte_t;

  class codec_scoreboard;
    logic        direction;
    logic        component_mode;
    logic        secondary_mode;
    logic [1:0]  esc_phase;
    logic [3:0]  high_nib;
    out_byte_t   expected_bytes[$];
    int unsigned errors;

    function new();
      direction      = 1'b0;
      component_mode = 1'b0;
      secondary_mode = 1'b0;
      esc_phase      = EscIdle;
      high_nib       = 4'h0;
      errors         = 0;
    endfunction

    function void set_reg(upc_pkg::cfg_idx_t idx, logic val);
      case (idx)
        upc_pkg::CfgDirection: direction      = val;
        upc_pkg::CfgComponent: component_mode = val;
        upc_pkg::CfgSecondary: secondary_mode = val;
        default: ;
      endcase
    endfunction

    function bit passes_unchanged(logic [7:0] c);
      if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9")) begin
        return 1'b1;
      end
      case (c)
        "-", "_", ".", "!", "~", "*", "'", "(", ")": return 1'b1;
        default: ;
      endcase
      if (!component_mode) begin
        case (c)
          ";", "/", "?", ":", "@", "&", "=", "+", "$", ",", "#": return 1'b1;
          upc_pkg::PctChar: return secondary_mode;
          default: ;
        endcase
      end
      return 1'b0;
    endfunction

    // Digit value, or 16 when the byte is not a hex digit.
    function logic [4:0] hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return 5'(c - "0");
      if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
      if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
      return 5'd16;
    endfunction

    function void note_accepted_byte(logic [7:0] c, logic last_of_string);
      logic [7:0] outs[$];
      logic [4:0] v;
      out_byte_t  r;
      outs = {};
      if (!direction) begin
        esc_phase = EscIdle;
        high_nib  = 4'h0;
        if (passes_unchanged(c)) begin
          outs.push_back(c);
        end else begin
          outs.push_back(upc_pkg::PctChar);
          outs.push_back(HexDigits[c[7:4]]);
          outs.push_back(HexDigits[c[3:0]]);
        end
      end else begin
        v = hex_value(c);
        case (esc_phase)
          EscIdle: begin
            if (c == upc_pkg::PctChar) begin
              esc_phase = EscPct;
              high_nib  = 4'h0;
              if (last_of_string) outs.push_back(8'h00);
            end else begin
              outs.push_back(c);
            end
          end
          EscPct: begin
            if (!v[4]) begin
              high_nib  = v[3:0];
              esc_phase = EscHigh;
              if (last_of_string) outs.push_back({4'h0, v[3:0]});
            end else begin
              high_nib  = 4'h0;
              esc_phase = EscBad;
              if (last_of_string) outs.push_back(8'h00);
            end
          end
          EscHigh: begin
            outs.push_back(!v[4] ? {high_nib, v[3:0]} : {4'h0, high_nib});
            esc_phase = EscIdle;
          end
          default: begin
            outs.push_back(8'h00);
            esc_phase = EscIdle;
          end
        endcase
        if (last_of_string) begin
          esc_phase = EscIdle;
          high_nib  = 4'h0;
        end
      end
      foreach (outs[k]) begin
        r.data       = outs[k];
        r.run_last   = (k == outs.size() - 1);
        r.string_end = (k == outs.size() - 1) && last_of_string;
        expected_bytes.push_back(r);
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_out_byte(out_byte_t got);
      out_byte_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected result byte %h run_last %b string_end %b",
                         got.data, got.run_last, got.string_end));
      end else begin
        want = expected_bytes.pop_front();
        if (got != want) begin
          report($sformatf("byte %h/%h run_last %b/%b string_end %b/%b (got/expected)",
                           got.data, want.data, got.run_last, want.run_last,
                           got.string_end, want.string_end));
        end
      end
    endtask
  endclass

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        gaps_on = 1'b1;
  int unsigned cycles  = 0;

  codec_scoreboard sb = new();

  upc_in_if  in_if();
  upc_out_if out_if();
  upc_cfg_if cfg_if();

  uri_percent_codec_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == MaxCycles) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: check each transfer, then decide the next cycle's ready.
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      sb.check_out_byte('{out_if.out_byte, out_if.run_last, out_if.string_end});
    end
    out_if.ready <= !gaps_on || ($urandom_range(99) >= IdlePct);
  end

  function automatic logic [7:0] pick_hex();
    return HexText[$urandom_range(HexText.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_text();
    return UriText[$urandom_range(UriText.len() - 1)];
  endfunction

  // Valid stays high between back-to-back items; it only drops in a gap.
  task automatic send_item(input logic [7:0] b, input logic last_of_string);
    while (gaps_on && $urandom_range(99) < IdlePct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_end  <= last_of_string;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_accepted_byte(b, last_of_string);
  endtask

  task automatic send_str(input string s, input logic end_last);
    for (int k = 0; k < s.len(); k++) begin
      send_item(s[k], end_last && (k == s.len() - 1));
    end
  endtask

  // Decoder items may produce nothing, so allow the pipeline to empty fully.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic configure(input logic dir, input logic comp, input logic sec);
    upc_pkg::cfg_idx_t idx[4];
    logic              val[4];
    idx = '{upc_pkg::CfgDirection, upc_pkg::CfgComponent, upc_pkg::CfgSecondary,
            CfgUnused};
    val = '{dir, comp, sec, 1'($urandom_range(1))};
    for (int k = 0; k < 4; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[k];
      cfg_if.data  <= val[k];
      do @(posedge clk_i); while (!cfg_if.ready);
      sb.set_reg(idx[k], val[k]);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly well-formed escapes when decoding, with literals and noise mixed in.
  task automatic random_phase(input int n);
    int         sent;
    int         r;
    int         len;
    logic [7:0] seq[3];
    sent = 0;
    while (sent < n) begin
      r   = $urandom_range(99);
      len = 1;
      if (sb.direction) begin
        if (r < 55) begin
          seq = '{upc_pkg::PctChar, pick_hex(), pick_hex()};
          len = 3;
          if ($urandom_range(9) == 0) seq[$urandom_range(2, 1)] = 8'($urandom_range(255));
        end else if (r < 85) begin
          seq[0] = pick_text();
        end else begin
          seq[0] = 8'($urandom_range(255));
        end
      end else begin
        seq[0] = (r < 45) ? 8'($urandom_range(255)) : pick_text();
      end
      for (int k = 0; k < len; k++) begin
        send_item(seq[k], $urandom_range(99) < 8);
      end
      sent += len;
    end
  endtask

  initial begin
    logic [2:0] mode;
    logic [2:0] mode_table[8];
    mode_table = '{3'b000, 3'b100, 3'b010, 3'b111, 3'b001, 3'b110, 3'b011, 3'b101};
    in_if.valid   <= 1'b0;
    in_if.in_byte <= 8'h00;
    in_if.in_end  <= 1'b0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= upc_pkg::CfgDirection;
    cfg_if.data   <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Encoder: control bytes, top-bit bytes, letters, unreserved, space, reserved
    // delimiters and the percent sign under three component/secondary mode settings.
    configure(1'b0, 1'b0, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_str("Za~ ;%", 1'b1);
    settle();
    configure(1'b0, 1'b1, 1'b1);
    send_str(";%", 1'b1);
    settle();
    configure(1'b0, 1'b0, 1'b1);
    send_str("%", 1'b1);
    settle();

    // Decoder: full escape, bad first digit, bad second digit, escapes cut
    // short by the end of the string.
    configure(1'b1, 1'b0, 1'b0);
    send_str("%4a%G1%4Z", 1'b0);
    send_str("%", 1'b1);
    send_str("%b", 1'b1);
    send_str("%4", 1'b0);
    settle();

    // An encoding step in the middle of an escape drops that escape.
    configure(1'b0, 1'b0, 1'b0);
    send_str("Q", 1'b0);
    settle();
    configure(1'b1, 1'b0, 1'b0);
    send_str("1", 1'b1);

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      mode = (p < 8) ? mode_table[p] : 3'($urandom_range(7));
      configure(mode[2], mode[1], mode[0]);
      gaps_on = (p != 5);
      random_phase(PhaseItems);
    end
    gaps_on = 1'b1;
    settle();

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
